// ===== design/vfa_pkg.sv =====
// ============================================================================
// vfa_pkg: shared types and helpers for the vector fixed-point ALU
// Holds the command codes, the item structs and the saturation helper.
// ============================================================================
`default_nettype none

package vfa_pkg;

  // Width of every data field, set by the item format.
  localparam int DATA_WIDTH    = 32;
  // Default number of fraction bits.
  localparam int FRAC_BITS_DEF = 16;
  // Number of vector lanes.
  localparam int LANES         = 4;
  // Width of the widest value that is ever saturated.
  localparam int SAT_W         = 2 * DATA_WIDTH + 4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_SCALE = 4'd2,
    CMD_RECIP = 4'd3,
    CMD_MUL   = 4'd4,
    CMD_DIV   = 4'd5,
    CMD_NORM  = 4'd6,
    CMD_CROSS = 4'd7,
    CMD_DOT   = 4'd8,
    CMD_LERP  = 4'd9,
    CMD_MAG   = 4'd10,
    CMD_DIST  = 4'd11
  } cmd_t;

  // Lane sources of the cross product: lane i is a[u]*b[v] - a[v]*b[u].
  // The w lane points at x twice, so its difference is zero.
  localparam logic [1:0] CROSS_U [LANES] = '{2'd1, 2'd2, 2'd0, 2'd0};
  localparam logic [1:0] CROSS_V [LANES] = '{2'd2, 2'd0, 2'd1, 2'd0};

  typedef struct packed {
    logic [3:0] command;
    logic [2:0] dims;
    data_t      a_x;
    data_t      a_y;
    data_t      a_z;
    data_t      a_w;
    data_t      b_x;
    data_t      b_y;
    data_t      b_z;
    data_t      b_w;
    data_t      scalar_in;
  } operands_t;

  typedef struct packed {
    data_t res_x;
    data_t res_y;
    data_t res_z;
    data_t res_w;
    data_t res_scalar;
    logic  saturated;
  } results_t;

  typedef struct packed {
    logic  flag;
    data_t val;
  } sat_t;

  // Clamp a wide signed value to the data range and report clamping.
  function automatic sat_t sat_fn(input logic signed [SAT_W-1:0] v);
    sat_t                    r;
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      r.flag = 1'b1;
      r.val  = hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      r.flag = 1'b1;
      r.val  = lo[DATA_WIDTH-1:0];
    end else begin
      r.flag = 1'b0;
      r.val  = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/vfa_sqrt.sv =====
// ============================================================================
// vfa_sqrt: pipelined integer square root
// Restoring square root, one root bit per register stage, floor result.
// ============================================================================
`default_nettype none

module vfa_sqrt #(
  parameter int RB = vfa_pkg::DATA_WIDTH + 2
) (
  input  wire logic            clk,
  input  wire logic [2*RB-1:0] rad,
  output logic      [RB-1:0]   root
);
  import vfa_pkg::*;

  logic [RB+1:0]   rem_q  [RB];
  logic [RB-1:0]   root_q [RB];
  logic [2*RB-1:0] rad_q  [RB];

  logic [RB+1:0]   rem_in  [RB];
  logic [RB-1:0]   root_in [RB];
  logic [2*RB-1:0] rad_in  [RB];

  logic [RB+1:0]   rem_next  [RB];
  logic [RB-1:0]   root_next [RB];
  logic [2*RB-1:0] rad_next  [RB];

  // Each stage takes the previous stage's registers; the first takes the input.
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad;
    for (int k = 1; k < RB; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      rad_in[k]  = rad_q[k-1];
    end
  end

  // One trial subtraction per stage, consuming two radicand bits.
  always_comb begin : c_stage
    logic [RB+3:0] rem_sh;
    logic [RB+3:0] trial;
    logic          take;
    for (int k = 0; k < RB; k++) begin
      rem_sh       = {rem_in[k], rad_in[k][2*RB-1 -: 2]};
      trial        = {2'b00, root_in[k], 2'b01};
      take         = (rem_sh >= trial);
      rem_next[k]  = take ? (RB+2)'(rem_sh - trial) : (RB+2)'(rem_sh);
      root_next[k] = {root_in[k][RB-2:0], take};
      rad_next[k]  = {rad_in[k][2*RB-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RB; k++) begin
      rem_q[k]  <= rem_next[k];
      root_q[k] <= root_next[k];
      rad_q[k]  <= rad_next[k];
    end
  end

  assign root = root_q[RB-1];

endmodule

`default_nettype wire

// ===== design/vfa_div.sv =====
// ============================================================================
// vfa_div: pipelined saturating divider for one lane
// Unsigned restoring division, one quotient bit per stage, signed saturation.
// ============================================================================
`default_nettype none

module vfa_div #(
  parameter int DW = vfa_pkg::DATA_WIDTH,
  parameter int NW = vfa_pkg::DATA_WIDTH + vfa_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW:0]   den,
  input  wire logic          neg,
  output logic      [DW-1:0] quo,
  output logic               ovf
);
  import vfa_pkg::*;

  // Stage 0 checks for overflow; stages 1 to DW each make one quotient bit.
  logic [DW:0]   r_q  [DW+1];
  logic [DW-1:0] lo_q [DW+1];
  logic [DW-1:0] q_q  [DW+1];
  logic [DW:0]   d_q  [DW+1];
  logic          n_q  [DW+1];
  logic          o_q  [DW+1];

  logic [DW:0]   r_next  [DW+1];
  logic [DW-1:0] lo_next [DW+1];
  logic [DW-1:0] q_next  [DW+1];

  logic [DW-1:0] qm;
  logic [DW-1:0] quo_next;
  logic          ovf_next;

  // The high part of the numerator must stay below the divisor, or the
  // quotient does not fit; a zero divisor always lands here.
  always_comb begin : c_stage
    logic [DW+1:0] sh;
    logic          take;
    r_next[0]  = (DW+1)'(num[NW-1:DW]);
    lo_next[0] = num[DW-1:0];
    q_next[0]  = '0;
    for (int k = 1; k <= DW; k++) begin
      sh         = {r_q[k-1], lo_q[k-1][DW-1]};
      take       = (sh >= {1'b0, d_q[k-1]});
      r_next[k]  = take ? (DW+1)'(sh - {1'b0, d_q[k-1]}) : (DW+1)'(sh);
      lo_next[k] = {lo_q[k-1][DW-2:0], 1'b0};
      q_next[k]  = {q_q[k-1][DW-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    r_q[0]  <= r_next[0];
    lo_q[0] <= lo_next[0];
    q_q[0]  <= q_next[0];
    d_q[0]  <= den;
    n_q[0]  <= neg;
    o_q[0]  <= ((DW+1)'(num[NW-1:DW]) >= den);
    for (int k = 1; k <= DW; k++) begin
      r_q[k]  <= r_next[k];
      lo_q[k] <= lo_next[k];
      q_q[k]  <= q_next[k];
      d_q[k]  <= d_q[k-1];
      n_q[k]  <= n_q[k-1];
      o_q[k]  <= o_q[k-1];
    end
  end

  // Apply the sign and clamp to the signed range.
  assign qm = q_q[DW];

  always_comb begin
    if (!n_q[DW]) begin
      if (o_q[DW] || qm[DW-1]) begin
        quo_next = {1'b0, {(DW-1){1'b1}}};
        ovf_next = 1'b1;
      end else begin
        quo_next = qm;
        ovf_next = 1'b0;
      end
    end else begin
      if (o_q[DW] || (qm[DW-1] && (|qm[DW-2:0]))) begin
        quo_next = {1'b1, {(DW-1){1'b0}}};
        ovf_next = 1'b1;
      end else begin
        quo_next = DW'(0) - qm;
        ovf_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo <= quo_next;
    ovf <= ovf_next;
  end

endmodule

`default_nettype wire

// ===== design/vector_fixed_point_alu_top.sv =====
// ============================================================================
// vector_fixed_point_alu_top: four-lane fixed-point vector ALU
// Add, sub, scale, reciprocal, multiply, divide, normalize, cross, dot,
// lerp, magnitude and distance on signed fixed-point vectors, saturating.
// ============================================================================
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------
//  command   | in        | start / busy        | operands (operands_t)
//  result    | out       | done, one cycle     | result (results_t)
//
// One item is taken in every cycle; busy is always low. From start to done
// each item passes through six front stages, one stage per root bit in the
// square root, and one stage per quotient bit plus two in each lane
// divider. Reset clears only the valid bits; the block keeps no state
// between items. Results are never held.
//
`default_nettype none

module vector_fixed_point_alu_top #(
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire vfa_pkg::operands_t operands,
  output logic                    done,
  output vfa_pkg::results_t       result
);
  import vfa_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int OW     = W + 1;
  localparam int PW     = 2 * W + 2;
  localparam int VW     = 2 * W + 3;
  localparam int TW     = 2 * W + 4;
  localparam int RB     = W + 2;
  localparam int NW     = W + FRAC_BITS;
  localparam int DV_LAT = W + 2;

  typedef struct packed {
    logic [3:0]              cmd;
    logic [LANES-1:0]        en;
    data_t [LANES-1:0]       a;
    data_t [LANES-1:0]       b;
  } front_t;

  typedef struct packed {
    front_t            f;
    data_t [LANES-1:0] vres;
    logic              vflag;
    data_t             dres;
    logic              dflag;
    logic [RB-1:0]     root;
  } side_t;

  // Front valid bits and payload.
  logic va, vb, vc, vd, ve, vf;
  front_t fa, fb, fc, fd, fe;
  front_t fa_next;
  data_t  s_a;

  logic signed [OW-1:0] m0x_next [LANES], m0y_next [LANES];
  logic signed [OW-1:0] m1x_next [LANES], m1y_next [LANES];
  logic signed [OW-1:0] as_next  [LANES];
  logic signed [OW-1:0] m0x_b [LANES], m0y_b [LANES], m1x_b [LANES], m1y_b [LANES];
  logic signed [OW-1:0] as_b  [LANES], as_c  [LANES];
  logic signed [PW-1:0] p0_c  [LANES], p1_c  [LANES];
  logic signed [VW-1:0] v_next [LANES], v_d [LANES];
  logic signed [VW-1:0] s01_d, s23_d;
  data_t [LANES-1:0]    vres_next, vres_e;
  logic                 vflag_next, vflag_e;
  logic signed [TW-1:0] tot_e;
  sat_t                 dot_sat;

  side_t          sd_f;
  logic [TW-1:0]  rad_f;
  side_t          sq_side [RB];
  logic [RB-1:0]  sq_v;
  logic [RB-1:0]  sq_root;
  side_t          dv_in;
  side_t          dv_side [DV_LAT];
  logic [DV_LAT-1:0] dv_v;

  logic [NW-1:0] num_d [LANES];
  logic [W:0]    den_d [LANES];
  logic          neg_d [LANES];
  logic [W-1:0]  quo   [LANES];
  logic          ovf   [LANES];

  results_t result_next;

  assign busy = 1'b0;

  // Stage A: clamp the dimension (three for cross) and zero the lanes that are not in use.
  always_comb begin : c_stage_a
    logic [2:0]        n;
    data_t [LANES-1:0] ain;
    data_t [LANES-1:0] bin;
    ain = {operands.a_w, operands.a_z, operands.a_y, operands.a_x};
    bin = {operands.b_w, operands.b_z, operands.b_y, operands.b_x};
    if (operands.dims < 3'd2) begin
      n = 3'd2;
    end else if (operands.dims > 3'd4) begin
      n = 3'd4;
    end else begin
      n = operands.dims;
    end
    if (operands.command == CMD_CROSS) begin
      n = 3'd3;
    end
    fa_next.cmd = operands.command;
    for (int i = 0; i < LANES; i++) begin
      fa_next.en[i] = (3'(i) < n);
      fa_next.a[i]  = fa_next.en[i] ? ain[i] : '0;
      fa_next.b[i]  = fa_next.en[i] ? bin[i] : '0;
    end
  end

  // Stage B: choose multiplier operands per command, and add or subtract.
  always_comb begin : c_stage_b
    logic signed [OW-1:0] ai;
    logic signed [OW-1:0] bi;
    logic signed [OW-1:0] si;
    for (int i = 0; i < LANES; i++) begin
      ai = OW'($signed(fa.a[i]));
      bi = OW'($signed(fa.b[i]));
      si = OW'(s_a);
      m0x_next[i] = '0;
      m0y_next[i] = '0;
      m1x_next[i] = '0;
      m1y_next[i] = '0;
      as_next[i]  = '0;
      case (fa.cmd)
        CMD_ADD: as_next[i] = ai + bi;
        CMD_SUB: as_next[i] = ai - bi;
        CMD_SCALE: begin
          m0x_next[i] = ai;
          m0y_next[i] = si;
        end
        CMD_MUL, CMD_DOT: begin
          m0x_next[i] = ai;
          m0y_next[i] = bi;
        end
        CMD_NORM, CMD_MAG: begin
          m0x_next[i] = ai;
          m0y_next[i] = ai;
        end
        CMD_LERP: begin
          m0x_next[i] = bi - ai;
          m0y_next[i] = si;
        end
        CMD_DIST: begin
          m0x_next[i] = ai - bi;
          m0y_next[i] = ai - bi;
        end
        CMD_CROSS: begin
          m0x_next[i] = OW'($signed(fa.a[CROSS_U[i]]));
          m0y_next[i] = OW'($signed(fa.b[CROSS_V[i]]));
          m1x_next[i] = OW'($signed(fa.a[CROSS_V[i]]));
          m1y_next[i] = OW'($signed(fa.b[CROSS_U[i]]));
        end
        default: ;
      endcase
    end
  end

  // Stage D: combine each lane's products into its exact unshifted value.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      case (fc.cmd)
        CMD_ADD, CMD_SUB: v_next[i] = VW'(as_c[i]) <<< FRAC_BITS;
        CMD_SCALE, CMD_MUL: v_next[i] = VW'(p0_c[i]);
        CMD_LERP: v_next[i] = (VW'($signed(fc.a[i])) <<< FRAC_BITS) + VW'(p0_c[i]);
        CMD_CROSS: v_next[i] = VW'(p0_c[i]) - VW'(p1_c[i]);
        default: v_next[i] = '0;
      endcase
    end
  end

  // Stage E: shift and clamp the vector lanes.
  always_comb begin : c_stage_e
    sat_t                 st;
    logic signed [VW-1:0] sh;
    vflag_next = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sh           = v_d[i] >>> FRAC_BITS;
      st           = sat_fn(SAT_W'(sh));
      vres_next[i] = st.val;
      vflag_next   = vflag_next | st.flag;
    end
  end

  // Stage F: dot product result; the sum of squares feeds the square root.
  assign dot_sat = sat_fn(SAT_W'(tot_e >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      va <= start && !busy;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  // Front payload registers.
  always_ff @(posedge clk) begin
    fa  <= fa_next;
    s_a <= operands.scalar_in;
    fb  <= fa;
    fc  <= fb;
    fd  <= fc;
    fe  <= fd;
    for (int i = 0; i < LANES; i++) begin
      m0x_b[i] <= m0x_next[i];
      m0y_b[i] <= m0y_next[i];
      m1x_b[i] <= m1x_next[i];
      m1y_b[i] <= m1y_next[i];
      as_b[i]  <= as_next[i];
      p0_c[i]  <= m0x_b[i] * m0y_b[i];
      p1_c[i]  <= m1x_b[i] * m1y_b[i];
      as_c[i]  <= as_b[i];
      v_d[i]   <= v_next[i];
    end
    s01_d   <= VW'(p0_c[0]) + VW'(p0_c[1]);
    s23_d   <= VW'(p0_c[2]) + VW'(p0_c[3]);
    vres_e  <= vres_next;
    vflag_e <= vflag_next;
    tot_e   <= TW'(s01_d) + TW'(s23_d);
    sd_f.f     <= fe;
    sd_f.vres  <= vres_e;
    sd_f.vflag <= vflag_e;
    sd_f.dres  <= dot_sat.val;
    sd_f.dflag <= dot_sat.flag;
    sd_f.root  <= '0;
    rad_f      <= tot_e;
  end

  vfa_sqrt #(
    .RB (RB)
  ) u_sqrt (
    .clk  (clk),
    .rad  (rad_f),
    .root (sq_root)
  );

  // Divider operands, formed as each item leaves the square root.
  always_comb begin : c_div_in
    side_t              s;
    logic signed [W:0]  ax;
    logic signed [W:0]  bx;
    logic [W:0]         abs_a;
    logic [W:0]         abs_b;
    s = sq_side[RB-1];
    for (int i = 0; i < LANES; i++) begin
      ax    = (W+1)'($signed(s.f.a[i]));
      bx    = (W+1)'($signed(s.f.b[i]));
      abs_a = ax[W] ? (W+1)'(-ax) : (W+1)'(ax);
      abs_b = bx[W] ? (W+1)'(-bx) : (W+1)'(bx);
      case (s.f.cmd)
        CMD_RECIP: begin
          num_d[i] = NW'(1) << (2 * FRAC_BITS);
          den_d[i] = abs_a;
          neg_d[i] = ax[W];
        end
        CMD_DIV: begin
          num_d[i] = NW'(abs_a) << FRAC_BITS;
          den_d[i] = abs_b;
          neg_d[i] = ax[W] ^ bx[W];
        end
        CMD_NORM: begin
          num_d[i] = NW'(abs_a) << FRAC_BITS;
          den_d[i] = sq_root[W:0];
          neg_d[i] = ax[W];
        end
        default: begin
          num_d[i] = '0;
          den_d[i] = '0;
          neg_d[i] = 1'b0;
        end
      endcase
    end
    dv_in      = s;
    dv_in.root = sq_root;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vfa_div #(
      .DW (W),
      .NW (NW)
    ) u_div (
      .clk (clk),
      .num (num_d[i]),
      .den (den_d[i]),
      .neg (neg_d[i]),
      .quo (quo[i]),
      .ovf (ovf[i])
    );
  end

  // Valid bits for the square root and divider sections.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
      dv_v <= '0;
      done <= 1'b0;
    end else begin
      sq_v <= {sq_v[RB-2:0], vf};
      dv_v <= {dv_v[DV_LAT-2:0], sq_v[RB-1]};
      done <= dv_v[DV_LAT-1];
    end
  end

  // Side data travels beside the square root and the dividers.
  always_ff @(posedge clk) begin
    sq_side[0] <= sd_f;
    for (int k = 1; k < RB; k++) begin
      sq_side[k] <= sq_side[k-1];
    end
    dv_side[0] <= dv_in;
    for (int k = 1; k < DV_LAT; k++) begin
      dv_side[k] <= dv_side[k-1];
    end
  end

  // Output selection by command.
  always_comb begin : c_out
    side_t             s;
    data_t [LANES-1:0] lv;
    data_t             sc;
    logic              fl;
    sat_t              ms;
    s  = dv_side[DV_LAT-1];
    lv = '0;
    sc = '0;
    fl = 1'b0;
    ms = sat_fn(SAT_W'(s.root));
    case (s.f.cmd)
      CMD_ADD, CMD_SUB, CMD_SCALE, CMD_MUL, CMD_CROSS, CMD_LERP: begin
        lv = s.vres;
        fl = s.vflag;
      end
      CMD_RECIP, CMD_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          if (s.f.en[i]) begin
            lv[i] = quo[i];
            fl    = fl | ovf[i];
          end
        end
      end
      CMD_NORM: begin
        if (s.root != '0) begin
          for (int i = 0; i < LANES; i++) begin
            if (s.f.en[i]) begin
              lv[i] = quo[i];
              fl    = fl | ovf[i];
            end
          end
        end
      end
      CMD_DOT: begin
        sc = s.dres;
        fl = s.dflag;
      end
      CMD_MAG, CMD_DIST: begin
        sc = ms.val;
        fl = ms.flag;
      end
      default: ;
    endcase
    result_next.res_x      = lv[0];
    result_next.res_y      = lv[1];
    result_next.res_z      = lv[2];
    result_next.res_w      = lv[3];
    result_next.res_scalar = sc;
    result_next.saturated  = fl;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire
